// File: sv/sliding_window_median_defines.svh
// ----------------------------------------------------------------------------
// Sliding window median: shared assertion macros
// Both macros are clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Types and fixed constants shared by the sliding window median modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

  // Width of the window length register and its value after reset.
  localparam int CFG_W      = 7;
  localparam int LEN_RESET  = 3;

  // Depth of the result queue in front of the output port.
  localparam int OUTQ_DEPTH = 3;

  // Operation applied to the whole cell row at once.
  typedef struct packed {
    logic ins;     // a new value enters the row
    logic clear;   // the row empties first
    logic del_en;  // the entry that falls out of the window leaves
  } swm_op_t;

  // What each cell tells its neighbors about itself.
  typedef struct packed {
    logic v;       // holds a value
    logic g;       // sits at or above the insertion point
    logic pb;      // sits above the entry being removed
    logic del;     // is the entry being removed
  } swm_flags_t;

endpackage

// File: sv/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted row: holds a sample and its age and takes its next
// content from itself, a neighbor or the incoming sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_cell #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int IDX_W        = 6,
  parameter int IDX          = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swm_pkg::swm_op_t               op,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic signed [SAMPLE_WIDTH-1:0] delval,
  input  logic        [IDX_W-1:0]        oldest_age,
  input  logic        [IDX_W-1:0]        tap_lo_idx,
  input  logic        [IDX_W-1:0]        tap_hi_idx,
  input  swm_pkg::swm_flags_t            fl_dn,
  input  logic signed [SAMPLE_WIDTH-1:0] d_dn,
  input  logic        [IDX_W-1:0]        age_dn,
  input  swm_pkg::swm_flags_t            fl_up,
  input  logic signed [SAMPLE_WIDTH-1:0] d_up,
  input  logic        [IDX_W-1:0]        age_up,
  output swm_pkg::swm_flags_t            fl,
  output logic signed [SAMPLE_WIDTH-1:0] d,
  output logic        [IDX_W-1:0]        age,
  output logic signed [SAMPLE_WIDTH-1:0] tap_lo,
  output logic signed [SAMPLE_WIDTH-1:0] tap_hi
);

  localparam bit IS_FIRST = (IDX == 0);

  logic                           v_r, v_nxt;
  logic signed [SAMPLE_WIDTH-1:0] d_r, d_nxt;
  logic        [IDX_W-1:0]        age_r, age_nxt;
  swm_pkg::swm_flags_t            my;
  logic                           below_del;
  logic                           take_x, stay, from_dn, from_up;

  // Entries are ordered by value, then by age, so the one being removed has
  // a unique place and each cell can tell on its own whether it lies below.
  always_comb begin
    below_del = (d_r < delval) || ((d_r == delval) && (age_r < oldest_age));
    my.v      = v_r;
    my.del    = op.del_en && v_r && (age_r == oldest_age);
    my.g      = !v_r || (d_r >= x);
    my.pb     = op.del_en && !(v_r && (below_del || my.del));
  end

  always_comb begin
    take_x  = (my.g && !fl_dn.g && !my.pb) || (fl_up.g && !my.g && fl_up.pb);
    stay    = !my.del && (my.pb == my.g);
    from_dn = !fl_dn.del && fl_dn.g && !fl_dn.pb;
    from_up = !fl_up.del && fl_up.pb && !fl_up.g;
    v_nxt   = v_r;
    d_nxt   = d_r;
    age_nxt = age_r;
    if (op.clear) begin
      v_nxt   = op.ins && IS_FIRST;
      d_nxt   = x;
      age_nxt = '0;
    end else if (op.ins) begin
      priority if (take_x) begin
        v_nxt   = 1'b1;
        d_nxt   = x;
        age_nxt = '0;
      end else if (stay) begin
        age_nxt = age_r + 1'b1;
      end else if (from_dn) begin
        v_nxt   = fl_dn.v;
        d_nxt   = d_dn;
        age_nxt = age_dn + 1'b1;
      end else if (from_up) begin
        v_nxt   = fl_up.v;
        d_nxt   = d_up;
        age_nxt = age_up + 1'b1;
      end else begin
        v_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    age_r <= age_nxt;
  end

  assign fl     = my;
  assign d      = d_r;
  assign age    = age_r;
  assign tap_lo = (tap_lo_idx == IDX_W'(IDX)) ? d_r : '0;
  assign tap_hi = (tap_hi_idx == IDX_W'(IDX)) ? d_r : '0;

endmodule

// File: sv/swm_chain.sv
// ----------------------------------------------------------------------------
// swm_chain
// Row of sorted cells holding the current window, lowest value in cell 0,
// with the broadcast of the leaving value and the two median taps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_median_defines.svh"

module swm_chain #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16,
  parameter int IDX_W        = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swm_pkg::swm_op_t               op,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic        [IDX_W-1:0]        oldest_age,
  input  logic        [IDX_W-1:0]        tap_lo_idx,
  input  logic        [IDX_W-1:0]        tap_hi_idx,
  output logic signed [SAMPLE_WIDTH-1:0] med_lo,
  output logic signed [SAMPLE_WIDTH-1:0] med_hi
);

  swm_pkg::swm_flags_t            fl_a   [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] d_a    [WINDOW_MAX];
  logic        [IDX_W-1:0]        age_a  [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] tlo_a  [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] thi_a  [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] delval;
  logic        [WINDOW_MAX-1:0]   vld_vec, del_vec, sort_ok;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_pkg::swm_flags_t            fl_dn, fl_up;
    logic signed [SAMPLE_WIDTH-1:0] d_dn, d_up;
    logic        [IDX_W-1:0]        age_dn, age_up;

    if (i == 0) begin : g_lo_edge
      assign fl_dn  = '{v: 1'b0, g: 1'b0, pb: 1'b0, del: 1'b0};
      assign d_dn   = '0;
      assign age_dn = '0;
    end else begin : g_lo_link
      assign fl_dn  = fl_a[i-1];
      assign d_dn   = d_a[i-1];
      assign age_dn = age_a[i-1];
    end

    // Past the top cell the row looks empty: everything there lies above
    // the insertion point and above any removed entry.
    if (i == WINDOW_MAX - 1) begin : g_hi_edge
      assign fl_up  = '{v: 1'b0, g: 1'b1, pb: op.del_en, del: 1'b0};
      assign d_up   = '0;
      assign age_up = '0;
    end else begin : g_hi_link
      assign fl_up  = fl_a[i+1];
      assign d_up   = d_a[i+1];
      assign age_up = age_a[i+1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .IDX_W        (IDX_W),
      .IDX          (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .x          (x),
      .delval     (delval),
      .oldest_age (oldest_age),
      .tap_lo_idx (tap_lo_idx),
      .tap_hi_idx (tap_hi_idx),
      .fl_dn      (fl_dn),
      .d_dn       (d_dn),
      .age_dn     (age_dn),
      .fl_up      (fl_up),
      .d_up       (d_up),
      .age_up     (age_up),
      .fl         (fl_a[i]),
      .d          (d_a[i]),
      .age        (age_a[i]),
      .tap_lo     (tlo_a[i]),
      .tap_hi     (thi_a[i])
    );
  end

  always_comb begin
    delval = '0;
    med_lo = '0;
    med_hi = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      delval     = delval | (fl_a[i].del ? d_a[i] : '0);
      med_lo     = med_lo | tlo_a[i];
      med_hi     = med_hi | thi_a[i];
      vld_vec[i] = fl_a[i].v;
      del_vec[i] = fl_a[i].del;
    end
  end

  always_comb begin
    sort_ok = '1;
    for (int i = 0; i < WINDOW_MAX - 1; i++) begin
      sort_ok[i] = !fl_a[i+1].v || (d_a[i] <= d_a[i+1]);
    end
  end

  // Occupied cells always form one run starting at cell 0.
  `SWM_ASSERT_IMP(a_vld_prefix, 1'b1, ((vld_vec & (vld_vec + 1'b1)) == '0), "cell row has a gap")
  `SWM_ASSERT_IMP(a_sorted, 1'b1, (&sort_ok), "cell row out of order")
  `SWM_ASSERT_IMP(a_one_leaves, op.del_en, $onehot(del_vec), "not exactly one entry leaves")

endmodule

// File: sv/swm_ring.sv
// ----------------------------------------------------------------------------
// swm_ring
// Arrival-order sample store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_ring #(
  parameter int DEPTH = 64,
  parameter int DW    = 16,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic        [AW-1:0] waddr,
  input  logic signed [DW-1:0] wdata,
  input  logic                 re,
  input  logic        [AW-1:0] raddr,
  output logic signed [DW-1:0] rdata
);

  logic signed [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/swm_outq.sv
// ----------------------------------------------------------------------------
// swm_outq
// Small result queue that drives the output channel from registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_outq #(
  parameter int DW = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic signed [DW-1:0] push_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] out_data,
  output logic [$clog2(swm_pkg::OUTQ_DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(swm_pkg::OUTQ_DEPTH);
  localparam int CNT_W = $clog2(swm_pkg::OUTQ_DEPTH + 1);

  logic signed [DW-1:0] mem [swm_pkg::OUTQ_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(swm_pkg::OUTQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(swm_pkg::OUTQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/sliding_window_median.sv
// ----------------------------------------------------------------------------
// Sliding window median filter
// Input requests carry a signed sample and a start flag that empties the
// window first. Once the window holds window_length samples, each request
// yields twice the median of the latest window_length samples.
// Throughput is one request per cycle while in_ready is high: a row of sorted
// cells inserts the new sample and drops the leaving one in a single step. The
// result is read from the registered cell row and pushed into a 3-entry
// queue; in_ready also drops when that queue and the result in flight would
// overflow, so a stalled receiver backs up into the input once 3 results are
// pending.
// A write of window_length reloads the cell row from the sample store, one
// sample a cycle, min(samples held, new length) samples in all; in_ready stays
// low until the reload is done.
// After reset the window is empty and window_length is 3.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_median_defines.svh"

module sliding_window_median #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]  in_sample,
  input  logic                            in_start_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_WIDTH:0]    out_median_doubled,
  input  logic                            cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0]       cfg_wr_data
);

  localparam int LEN_W   = $clog2(WINDOW_MAX + 1);
  localparam int LW1     = LEN_W + 1;
  localparam int IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMP_W   = (LEN_W > swm_pkg::CFG_W) ? LEN_W : swm_pkg::CFG_W;
  localparam int LEN_RST = (swm_pkg::LEN_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                             : swm_pkg::LEN_RESET;
  localparam int Q_CNT_W = $clog2(swm_pkg::OUTQ_DEPTH + 1);
  localparam int QL_W    = Q_CNT_W + 1;

  typedef enum logic {ST_RUN, ST_REBUILD} seq_state_t;

  seq_state_t                     state_r;
  logic [LEN_W-1:0]               len_r, fill_r, rb_cnt_r;
  logic [LEN_W-1:0]               new_len, rb_len, fill_inc, fill_nxt, len_m1, tap_hi_full;
  logic [CMP_W-1:0]               cfg_ext;
  logic [LW1-1:0]                 rb_start_raw, rb_start_wrap;
  logic [IDX_W-1:0]               ptr_r, rd_addr_r, wr_addr, ptr_adv, rd_addr_adv;
  logic [IDX_W-1:0]               oldest_age, tap_lo_idx, tap_hi_idx;
  logic                           rd_vld_r, rd_issue, p_r, acc, due, del_en;
  logic signed [SAMPLE_WIDTH-1:0] rd_data, chain_x, med_lo, med_hi;
  logic signed [SAMPLE_WIDTH:0]   med_sum;
  swm_pkg::swm_op_t               op;
  logic [Q_CNT_W-1:0]             q_count;
  logic [QL_W-1:0]                q_load;

  // Window length as written, folded into 1..WINDOW_MAX.
  always_comb begin
    cfg_ext = CMP_W'(cfg_wr_data);
    if (cfg_wr_data == '0) begin
      new_len = LEN_W'(1);
    end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
      new_len = LEN_W'(WINDOW_MAX);
    end else begin
      new_len = LEN_W'(cfg_ext);
    end
    rb_len       = (fill_r < new_len) ? fill_r : new_len;
    rb_start_raw = LW1'(ptr_r) + LW1'(WINDOW_MAX) - LW1'(rb_len);
    rb_start_wrap = (rb_start_raw >= LW1'(WINDOW_MAX)) ? rb_start_raw - LW1'(WINDOW_MAX)
                                                       : rb_start_raw;
  end

  // The two middle cells of a full window: (len - 1) / 2 and len / 2.
  assign len_m1      = len_r - LEN_W'(1);
  assign tap_hi_full = len_r >> 1;
  assign oldest_age  = len_m1[IDX_W-1:0];
  assign tap_lo_idx  = IDX_W'(len_m1 >> 1);
  assign tap_hi_idx  = IDX_W'(tap_hi_full);

  // Result credit: queue entries plus the result being formed this cycle.
  assign q_load   = {1'b0, q_count} + QL_W'(p_r);
  assign in_ready = (state_r == ST_RUN) && (q_load <= QL_W'(swm_pkg::OUTQ_DEPTH - 1));
  assign acc      = in_valid && in_ready;

  always_comb begin
    fill_inc = (fill_r == LEN_W'(WINDOW_MAX)) ? fill_r : fill_r + 1'b1;
    fill_nxt = in_start_req ? LEN_W'(1) : fill_inc;
    due      = (fill_nxt >= len_r);
    del_en   = !in_start_req && (fill_r >= len_r);
    wr_addr  = in_start_req ? '0 : ptr_r;
    ptr_adv  = (wr_addr == IDX_W'(WINDOW_MAX - 1)) ? '0 : wr_addr + 1'b1;
    rd_addr_adv = (rd_addr_r == IDX_W'(WINDOW_MAX - 1)) ? '0 : rd_addr_r + 1'b1;
    rd_issue = (state_r == ST_REBUILD) && (rb_cnt_r != '0) && !cfg_wr_en;
  end

  always_comb begin
    chain_x = in_sample;
    priority if (cfg_wr_en) begin
      op = '{ins: 1'b0, clear: 1'b1, del_en: 1'b0};
    end else if (rd_vld_r) begin
      op      = '{ins: 1'b1, clear: 1'b0, del_en: 1'b0};
      chain_x = rd_data;
    end else if (acc) begin
      op = '{ins: 1'b1, clear: in_start_req, del_en: del_en};
    end else begin
      op = '{ins: 1'b0, clear: 1'b0, del_en: 1'b0};
    end
  end

  // Reload sequencer: after a length change the cell row is refilled with
  // the newest samples, oldest first, so ages come out right.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      rb_cnt_r  <= '0;
      rd_addr_r <= '0;
      rd_vld_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      state_r   <= ST_REBUILD;
      rb_cnt_r  <= rb_len;
      rd_addr_r <= rb_start_wrap[IDX_W-1:0];
      rd_vld_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_RUN: begin
          rd_vld_r <= 1'b0;
        end
        ST_REBUILD: begin
          rd_vld_r <= rd_issue;
          if (rd_issue) begin
            rb_cnt_r  <= rb_cnt_r - 1'b1;
            rd_addr_r <= rd_addr_adv;
          end
          if ((rb_cnt_r == '0) && !rd_vld_r) begin
            state_r <= ST_RUN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= LEN_W'(LEN_RST);
      fill_r <= '0;
      ptr_r  <= '0;
      p_r    <= 1'b0;
    end else begin
      p_r <= acc && due;
      if (cfg_wr_en) begin
        len_r <= new_len;
      end
      if (acc) begin
        fill_r <= fill_nxt;
        ptr_r  <= ptr_adv;
      end
    end
  end

  swm_ring #(
    .DEPTH (WINDOW_MAX),
    .DW    (SAMPLE_WIDTH),
    .AW    (IDX_W)
  ) u_ring (
    .clk   (clk),
    .we    (acc),
    .waddr (wr_addr),
    .wdata (in_sample),
    .re    (rd_issue),
    .raddr (rd_addr_r),
    .rdata (rd_data)
  );

  swm_chain #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .IDX_W        (IDX_W)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .x          (chain_x),
    .oldest_age (oldest_age),
    .tap_lo_idx (tap_lo_idx),
    .tap_hi_idx (tap_hi_idx),
    .med_lo     (med_lo),
    .med_hi     (med_hi)
  );

  // The two middle entries coincide for an odd window.
  assign med_sum = {med_lo[SAMPLE_WIDTH-1], med_lo} + {med_hi[SAMPLE_WIDTH-1], med_hi};

  swm_outq #(
    .DW (SAMPLE_WIDTH + 1)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (p_r),
    .push_data (med_sum),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_median_doubled),
    .count     (q_count)
  );

  `SWM_ASSERT_IMP(a_q_room, p_r, (q_count != Q_CNT_W'(swm_pkg::OUTQ_DEPTH)), "result queue overrun")
  `SWM_ASSERT_IMP(a_reload_excl, rd_vld_r, !acc, "request taken during reload")
  `SWM_ASSERT_NXT(a_start_fill, acc && in_start_req, (fill_r == LEN_W'(1)), "start did not restart fill")

endmodule

// File: verif/sliding_window_median_test.sv
// ----------------------------------------------------------------------------
// Sliding window median testbench
// Drives signed samples and start flags into sliding_window_median with random
// gaps on both handshakes. An in-house predictor keeps its own copy of the
// sample history and computes twice the median of the latest window. Every
// result is checked in order against it or against a table value. A short table
// covers the extremes and the special window lengths. Random phases under
// several window settings follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_median_test;

  localparam int CFG_W          = swm_pkg::CFG_W;
  localparam int LEN_RESET      = swm_pkg::LEN_RESET;
  localparam int HIST_DEPTH     = 64;
  localparam int IDLE_SETTLE    = 4;
  localparam int STALL_LIMIT    = 5000;
  localparam int N_DIR_ROWS     = 21;
  localparam int N_PHASES       = 8;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic                    cfg_wr;
    logic [CFG_W-1:0]        cfg_val;
    logic                    start;
    logic signed [15:0]      smp;
    logic                    typed;
    logic signed [16:0]      lit;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [15:0]      in_sample;
  logic                    in_start_req;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [16:0]      out_median_doubled;
  logic                    cfg_wr_en;
  logic [CFG_W-1:0]        cfg_wr_data;

  // Predictor state.
  logic signed [15:0]      sample_hist [HIST_DEPTH];
  logic [5:0]              hist_wptr;
  int                      hist_count;
  logic [CFG_W-1:0]        win_len;

  logic signed [16:0]      median_q [$];
  stim_row_t               dir_rows [N_DIR_ROWS];
  logic                    no_gaps;
  int                      err_cnt;
  int                      idle_cycles;

  sliding_window_median dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_start_req      (in_start_req),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_median_doubled(out_median_doubled),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic predict_median(input logic signed [15:0] smp, input logic start,
                                output logic has, output logic signed [16:0] med);
    int                 eff;
    int                 i;
    int                 j;
    logic signed [15:0] win_vals [HIST_DEPTH];
    logic signed [15:0] v;
    logic [5:0]         pos;
    eff = (win_len == 0) ? 1 : (win_len > HIST_DEPTH) ? HIST_DEPTH : int'(win_len);
    if (start) begin
      hist_count = 0;
      hist_wptr  = '0;
    end
    sample_hist[hist_wptr] = smp;
    hist_wptr = hist_wptr + 6'd1;
    if (hist_count < HIST_DEPTH) hist_count++;
    has = (hist_count >= eff);
    med = '0;
    if (has) begin
      // Insertion sort of the latest eff samples, newest first.
      for (i = 0; i < eff; i++) begin
        pos = hist_wptr - 6'd1 - 6'(i);
        v = sample_hist[pos];
        j = i;
        while (j > 0 && win_vals[j-1] > v) begin
          win_vals[j] = win_vals[j-1];
          j--;
        end
        win_vals[j] = v;
      end
      if (eff % 2 == 1) med = 17'(win_vals[eff/2]) + 17'(win_vals[eff/2]);
      else med = 17'(win_vals[eff/2-1]) + 17'(win_vals[eff/2]);
    end
  endtask

  // Offers one request after a random gap and returns at the edge that
  // accepts it, with in_valid still high.
  task automatic offer_sample(input logic signed [15:0] smp, input logic start,
                              input logic typed, input logic signed [16:0] lit);
    int                 gap;
    logic               has;
    logic signed [16:0] med;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample    <= smp;
    in_start_req <= start;
    do @(posedge clk); while (!in_ready);
    predict_median(smp, start, has, med);
    if (has) median_q.insert(median_q.size(), typed ? lit : med);
  endtask

  // The block must be idle before a write: all results back, and a request
  // with no result given time to settle.
  task automatic set_window(input logic [CFG_W-1:0] len);
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_len = len;
  endtask

  // Result side: random stalls and in-order checking.
  initial begin
    int                 stall_left;
    logic signed [16:0] exp_med;
    err_cnt    = 0;
    stall_left = 0;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (median_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("unexpected result %0d at %0t", out_median_doubled, $realtime);
        end else begin
          exp_med = median_q.pop_front();
          if (out_median_doubled !== exp_med) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("median mismatch at %0t: expected %0d, got %0d",
                       $realtime, exp_med, out_median_doubled);
          end
        end
        stall_left = no_gaps ? 0 : $urandom_range(0, 4);
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end
      end else if (!out_ready) begin
        if (stall_left == 0) out_ready <= 1'b1;
        else stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
        $display("sliding_window_median_test: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int                 ph;
    int                 k;
    int                 n_items;
    int                 eff;
    logic [CFG_W-1:0]   len;
    logic signed [15:0] smp;
    logic               start;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_sample    <= '0;
    in_start_req <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    no_gaps      = 1'b0;
    hist_count   = 0;
    hist_wptr    = '0;
    win_len      = CFG_W'(LEN_RESET);

    // cfg_wr, cfg_val, start, sample, typed, expected doubled median
    dir_rows[0]  = '{1'b0, 7'd0,   1'b1, 16'sd32767,  1'b0, 17'sd0};
    dir_rows[1]  = '{1'b0, 7'd0,   1'b0, 16'sh8000,   1'b0, 17'sd0};
    dir_rows[2]  = '{1'b0, 7'd0,   1'b0, 16'sd32767,  1'b1, 17'sd65534};
    dir_rows[3]  = '{1'b0, 7'd0,   1'b0, 16'sh8000,   1'b1, 17'sh10000};
    dir_rows[4]  = '{1'b0, 7'd0,   1'b0, 16'sh8000,   1'b1, 17'sh10000};
    // A start request in the middle of a sequence empties the window.
    dir_rows[5]  = '{1'b0, 7'd0,   1'b1, 16'sd5,      1'b0, 17'sd0};
    dir_rows[6]  = '{1'b0, 7'd0,   1'b0, 16'sd0,      1'b0, 17'sd0};
    dir_rows[7]  = '{1'b0, 7'd0,   1'b0, -16'sd1,     1'b1, 17'sd0};
    // A zero length acts as a window of one.
    dir_rows[8]  = '{1'b1, 7'd0,   1'b1, 16'sd1234,   1'b1, 17'sd2468};
    dir_rows[9]  = '{1'b0, 7'd0,   1'b0, -16'sd7,     1'b1, -17'sd14};
    dir_rows[10] = '{1'b1, 7'd2,   1'b1, 16'sd100,    1'b0, 17'sd0};
    dir_rows[11] = '{1'b0, 7'd0,   1'b0, 16'sd201,    1'b1, 17'sd301};
    dir_rows[12] = '{1'b0, 7'd0,   1'b0, 16'sh8000,   1'b1, -17'sd32567};
    // The length grows mid-sequence, without a start request.
    dir_rows[13] = '{1'b1, 7'd3,   1'b0, 16'sd7,      1'b1, 17'sd14};
    dir_rows[14] = '{1'b1, 7'd1,   1'b0, 16'sd0,      1'b1, 17'sd0};
    dir_rows[15] = '{1'b1, 7'd4,   1'b1, 16'sd3,      1'b0, 17'sd0};
    dir_rows[16] = '{1'b0, 7'd0,   1'b0, -16'sd3,     1'b0, 17'sd0};
    dir_rows[17] = '{1'b0, 7'd0,   1'b0, 16'sd9,      1'b0, 17'sd0};
    dir_rows[18] = '{1'b0, 7'd0,   1'b0, -16'sd9,     1'b1, 17'sd0};
    dir_rows[19] = '{1'b0, 7'd0,   1'b0, 16'sd32767,  1'b0, 17'sd0};
    dir_rows[20] = '{1'b1, 7'd2,   1'b0, 16'sh8000,   1'b0, 17'sd0};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < N_DIR_ROWS; k++) begin
      if (dir_rows[k].cfg_wr) set_window(dir_rows[k].cfg_val);
      offer_sample(dir_rows[k].smp, dir_rows[k].start, dir_rows[k].typed, dir_rows[k].lit);
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       len = 7'd127;
        1:       len = 7'd1;
        2:       len = 7'd2;
        3:       len = 7'd64;
        4:       len = 7'd0;
        5:       len = 7'd7;
        6:       len = CFG_W'($urandom_range(3, 16));
        default: len = CFG_W'($urandom_range(0, 127));
      endcase
      set_window(len);
      no_gaps = (ph % 3 == 2);
      eff = (len == 0) ? 1 : (len > HIST_DEPTH) ? HIST_DEPTH : int'(len);
      n_items = (eff > 16) ? eff + 20 : 32;
      for (k = 0; k < n_items; k++) begin
        case ($urandom_range(0, 9))
          0:       smp = $urandom_range(0, 1) ? 16'sd32767 : 16'sh8000;
          1, 2, 3: smp = 16'($signed($urandom_range(0, 6)) - 3);
          default: smp = 16'($urandom);
        endcase
        // Mostly long sequences; an occasional restart acts as noise.
        if (k == 0) start = ($urandom_range(0, 3) != 0);
        else start = ($urandom_range(0, 39) == 0);
        offer_sample(smp, start, 1'b0, 17'sd0);
        if ((ph == 0 && k == 20) || $urandom_range(0, 49) == 0) begin
          in_valid <= 1'b0;
          while (median_q.size() != 0) @(posedge clk);
          @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && median_q.size() == 0) begin
      $display("sliding_window_median_test: PASS");
    end else begin
      $display("sliding_window_median_test: FAIL");
    end
    $finish;
  end

endmodule
